### design/lom_pkg.sv
// Shared types and constants for the limit order matcher.
package lom_pkg;

	localparam int unsigned BookDepthDefault = 32;

	localparam logic FuncAdd    = 1'b0;
	localparam logic FuncCancel = 1'b1;
	localparam logic SideBuy    = 1'b0;
	localparam logic SideSell   = 1'b1;

	localparam logic KindTrade = 1'b0;
	localparam logic KindDone  = 1'b1;

	localparam logic [1:0] StDone    = 2'd0;
	localparam logic [1:0] StRested  = 2'd1;
	localparam logic [1:0] StFull    = 2'd2;
	localparam logic [1:0] StIgnored = 2'd3;

	typedef struct packed {
		logic        func;
		logic        side;
		logic [15:0] price;
		logic [23:0] quantity;
		logic [31:0] order_id;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [23:0] trade_quantity;
		logic [15:0] trade_price;
		logic [31:0] counter_id;
		logic [23:0] rested_quantity;
		logic [1:0]  status;
		logic [5:0]  removed_count;
		logic        last;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the request
		logic scan_clr;   // reset scan index and best tracker
		logic scan_step;  // evaluate one slot
		logic cancel_step;// cancel check on one slot
		logic fill;       // apply fill against best
		logic rest;       // place remainder into free slot
		logic emit_trade;
		logic emit_done;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_cancel;
		logic qty_zero;   // nothing left to fill
		logic scan_last;
		logic best_found;
		logic fill_done;  // a fill against the best slot uses up the remainder
	} sts_t;

endpackage

### design/lom_ctrl.sv
// Controller state machine for the limit order matcher.
module lom_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lom_pkg::sts_t sts,
	output lom_pkg::cmd_t cmd
);
	import lom_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_CANCEL = 6'b000100,
		S_SCAN   = 6'b001000,
		S_FILL   = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.scan_clr = 1'b1;
				if (sts.is_cancel) state_d = S_CANCEL;
				else if (sts.qty_zero) state_d = S_FINISH;
				else state_d = S_SCAN;
			end
			S_CANCEL: begin
				cmd.cancel_step = 1'b1;
				if (sts.scan_last) state_d = S_FINISH;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = S_FILL;
			end
			S_FILL: begin
				if (sts.best_found) begin
					cmd.fill = 1'b1;
					cmd.emit_trade = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = S_SCAN;
					if (sts.fill_done) state_d = S_FINISH;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				cmd.emit_done = 1'b1;
				cmd.rest = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

### design/lom_datapath.sv
// Order table, scan tracker and result formatting for the limit order matcher.
module lom_datapath #(
	parameter int unsigned BOOK_DEPTH = lom_pkg::BookDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lom_pkg::req_t req,
	input  lom_pkg::cmd_t cmd,
	output lom_pkg::sts_t sts,
	output logic          valid,
	output lom_pkg::rsp_t result
);
	import lom_pkg::*;

	localparam int unsigned IdxW = $clog2(BOOK_DEPTH);

	logic [BOOK_DEPTH-1:0] vld_q;
	logic [BOOK_DEPTH-1:0] side_q;
	logic [15:0] price_q [BOOK_DEPTH];
	logic [23:0] qty_q   [BOOK_DEPTH];
	logic [31:0] id_q    [BOOK_DEPTH];
	logic [31:0] stamp_q [BOOK_DEPTH];
	logic [31:0] arrival_q;

	req_t        req_q;
	logic [23:0] rem_q;
	logic [IdxW-1:0] idx_q;
	logic        best_ok_q;
	logic [IdxW-1:0] best_q;
	logic [15:0] bprice_q;
	logic [31:0] bage_q;
	logic [5:0]  removed_q;
	logic        valid_q;
	rsp_t        result_q;
	rsp_t        rsp_d;

	// Candidate slot under scan
	logic [15:0] c_price;
	logic [31:0] c_age;
	logic        c_ok, c_better;
	always_comb begin
		c_price = price_q[idx_q];
		c_age   = arrival_q - stamp_q[idx_q];
		c_ok    = vld_q[idx_q] && (side_q[idx_q] != req_q.side) &&
			((req_q.side == SideBuy) ? (c_price <= req_q.price)
			                         : (c_price >= req_q.price));
		if (!best_ok_q) c_better = 1'b1;
		else if (c_price != bprice_q)
			c_better = (req_q.side == SideBuy) ? (c_price < bprice_q)
			                                   : (c_price > bprice_q);
		else c_better = c_age < bage_q;
	end

	// Fill amount against the best slot
	logic [23:0] fill_qty;
	assign fill_qty = (rem_q < qty_q[best_q]) ? rem_q : qty_q[best_q];

	// Lowest free slot
	logic          free_ok;
	logic [IdxW-1:0] free_idx;
	always_comb begin
		free_ok = 1'b0;
		free_idx = '0;
		for (int i = BOOK_DEPTH - 1; i >= 0; i--) begin
			if (!vld_q[i]) begin
				free_ok = 1'b1;
				free_idx = IdxW'(i);
			end
		end
	end

	always_comb begin
		sts.is_cancel  = (req_q.func == FuncCancel);
		sts.qty_zero   = (rem_q == '0);
		sts.scan_last  = (idx_q == IdxW'(BOOK_DEPTH - 1));
		sts.best_found = best_ok_q;
		sts.fill_done  = (rem_q == fill_qty);
	end

	// Next result record
	always_comb begin
		rsp_d = '0;
		if (cmd.emit_trade) begin
			rsp_d.kind           = KindTrade;
			rsp_d.trade_quantity = fill_qty;
			rsp_d.trade_price    = (req_q.side == SideBuy) ? price_q[best_q] : req_q.price;
			rsp_d.counter_id     = id_q[best_q];
		end
		if (cmd.emit_done) begin
			rsp_d.kind = KindDone;
			rsp_d.last = 1'b1;
			if (sts.is_cancel) begin
				rsp_d.status = StDone;
				rsp_d.removed_count = removed_q;
			end else if (req_q.quantity == '0) rsp_d.status = StIgnored;
			else if (rem_q == '0) rsp_d.status = StDone;
			else if (free_ok) begin
				rsp_d.status = StRested;
				rsp_d.rested_quantity = rem_q;
			end else rsp_d.status = StFull;
		end
	end

	// Control state of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			arrival_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= cmd.emit_trade | cmd.emit_done;
			if (cmd.cancel_step && vld_q[idx_q] && id_q[idx_q] == req_q.order_id)
				vld_q[idx_q] <= 1'b0;
			if (cmd.fill && qty_q[best_q] == fill_qty)
				vld_q[best_q] <= 1'b0;
			if (cmd.rest && !sts.is_cancel && rem_q != '0 && free_ok) begin
				vld_q[free_idx] <= 1'b1;
				arrival_q <= arrival_q + 32'd1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			rem_q <= req.quantity;
			removed_q <= '0;
		end
		if (cmd.scan_clr) begin
			idx_q <= '0;
			best_ok_q <= 1'b0;
		end
		if (cmd.scan_step || cmd.cancel_step) begin
			if (!sts.scan_last) idx_q <= idx_q + IdxW'(1);
		end
		if (cmd.scan_step && c_ok && c_better) begin
			best_ok_q <= 1'b1;
			best_q    <= idx_q;
			bprice_q  <= c_price;
			bage_q    <= c_age;
		end
		if (cmd.cancel_step && vld_q[idx_q] && id_q[idx_q] == req_q.order_id)
			removed_q <= removed_q + 6'd1;
		if (cmd.fill) begin
			rem_q <= rem_q - fill_qty;
			qty_q[best_q] <= qty_q[best_q] - fill_qty;
		end
		if (cmd.rest && !sts.is_cancel && rem_q != '0 && free_ok) begin
			side_q[free_idx]  <= req_q.side;
			price_q[free_idx] <= req_q.price;
			qty_q[free_idx]   <= rem_q;
			id_q[free_idx]    <= req_q.order_id;
			stamp_q[free_idx] <= arrival_q;
		end
		result_q <= rsp_d;
	end

	assign valid  = valid_q;
	assign result = result_q;

endmodule

### design/limit_order_matcher.sv
// A cancel checks every slot once for a matching id; an add with a nonzero quantity scans
// the whole table before each fill, and once more when a remainder is left after the fills.
// Each scan visits one slot per cycle to find the best order.
// One transaction at a time; results come on a strobe, and the
// receiver cannot stall them. Reset empties the book and clears the stamp counter.
module limit_order_matcher #(
	parameter int unsigned BOOK_DEPTH = lom_pkg::BookDepthDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lom_pkg::req_t request,
	output logic          strobe,
	output lom_pkg::rsp_t result
);
	import lom_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lom_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd)
	);

	lom_datapath #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(request), .cmd(cmd), .sts(sts),
		.valid(strobe), .result(result)
	);

	// A completion record ends the transaction: block returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |-> !busy)
		else $error("completion without return to idle");

	// Trade records always carry a nonzero fill
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> result.trade_quantity != '0)
		else $error("zero fill trade");

	// No result while idle before a start
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !strobe)
		else $error("result without transaction");
endmodule

### tb/sv/limit_order_matcher_test.sv
// Testbench for the limit order matcher: directed and random orders checked against a book model.
module limit_order_matcher_test;
	timeunit 1ns;
	timeprecision 1ps;
	import lom_pkg::*;

	localparam int Depth = 32;

	// Book model and queue of expected records
	class book_scoreboard;
		bit          valid [Depth];
		bit          bside [Depth];
		bit [15:0]   bprice [Depth];
		bit [23:0]   bqty [Depth];
		bit [31:0]   bid [Depth];
		bit [31:0]   bstamp [Depth];
		bit [31:0]   arrivals;
		rsp_t        pending [$];
		int          errors;

		function void push(logic kind, logic [23:0] tq, logic [15:0] tp, logic [31:0] cid,
				logic [23:0] rq, logic [1:0] st, logic [5:0] rc, logic lst);
			rsp_t r;
			r.kind = kind; r.trade_quantity = tq; r.trade_price = tp;
			r.counter_id = cid; r.rested_quantity = rq; r.status = st;
			r.removed_count = rc; r.last = lst;
			pending = {pending, r};
		endfunction

		function int best_counter(bit s, bit [15:0] p);
			int b;
			bit [15:0] bp;
			bit [31:0] bage, age;
			b = -1; bp = '0; bage = '0;
			for (int i = 0; i < Depth; i++) begin
				if (!valid[i] || bside[i] == s) continue;
				if (s == SideBuy ? (bprice[i] > p) : (bprice[i] < p)) continue;
				age = arrivals - bstamp[i];
				if (b < 0 || (bprice[i] != bp &&
						(s == SideBuy ? bprice[i] < bp : bprice[i] > bp)) ||
						(bprice[i] == bp && age < bage)) begin
					b = i; bp = bprice[i]; bage = age;
				end
			end
			return b;
		endfunction

		// Note an accepted request and predict its records
		function void note_request(req_t q);
			int b;
			int unsigned removed;
			bit [23:0] rem, fill;
			if (q.func == FuncCancel) begin
				removed = 0;
				for (int i = 0; i < Depth; i++)
					if (valid[i] && bid[i] == q.order_id) begin
						valid[i] = 1'b0;
						removed++;
					end
				push(KindDone, '0, '0, '0, '0, StDone, removed[5:0], 1'b1);
				return;
			end
			if (q.quantity == '0) begin
				push(KindDone, '0, '0, '0, '0, StIgnored, '0, 1'b1);
				return;
			end
			rem = q.quantity;
			while (rem != '0) begin
				b = best_counter(q.side, q.price);
				if (b < 0) break;
				fill = rem < bqty[b] ? rem : bqty[b];
				push(KindTrade, fill, q.side == SideBuy ? bprice[b] : q.price, bid[b],
					'0, StDone, '0, 1'b0);
				rem -= fill;
				bqty[b] -= fill;
				if (bqty[b] == '0) valid[b] = 1'b0;
			end
			if (rem == '0) begin
				push(KindDone, '0, '0, '0, '0, StDone, '0, 1'b1);
				return;
			end
			for (int i = 0; i < Depth; i++)
				if (!valid[i]) begin
					valid[i] = 1'b1; bside[i] = q.side; bprice[i] = q.price;
					bqty[i] = rem; bid[i] = q.order_id; bstamp[i] = arrivals;
					arrivals++;
					push(KindDone, '0, '0, '0, rem, StRested, '0, 1'b1);
					return;
				end
			push(KindDone, '0, '0, '0, '0, StFull, '0, 1'b1);
		endfunction

		// Compare one record with the oldest expectation
		function void check_result(rsp_t a);
			rsp_t e;
			if (pending.size() == 0) begin
				$error("unexpected record %p", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.kind != e.kind) begin
				$error("kind exp %0d got %0d", e.kind, a.kind); errors++;
			end
			if (a.trade_quantity != e.trade_quantity) begin
				$error("trade_quantity exp %0d got %0d", e.trade_quantity, a.trade_quantity);
				errors++;
			end
			if (a.trade_price != e.trade_price) begin
				$error("trade_price exp %0d got %0d", e.trade_price, a.trade_price); errors++;
			end
			if (a.counter_id != e.counter_id) begin
				$error("counter_id exp %h got %h", e.counter_id, a.counter_id); errors++;
			end
			if (a.rested_quantity != e.rested_quantity) begin
				$error("rested_quantity exp %0d got %0d", e.rested_quantity,
					a.rested_quantity);
				errors++;
			end
			if (a.status != e.status) begin
				$error("status exp %0d got %0d", e.status, a.status); errors++;
			end
			if (a.removed_count != e.removed_count) begin
				$error("removed_count exp %0d got %0d", e.removed_count, a.removed_count);
				errors++;
			end
			if (a.last != e.last) begin
				$error("last exp %0d got %0d", e.last, a.last); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic strobe;
	req_t request = '0;
	rsp_t result;
	book_scoreboard sb = new();
	int cycles = 0;
	bit [31:0] ids [$];

	limit_order_matcher #(.BOOK_DEPTH(Depth)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.request(request), .strobe(strobe), .result(result)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Result monitor and cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && strobe) sb.check_result(result);
		if (cycles > 2000000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Send one transaction after a random gap; start stays up when no gap follows
	task automatic send(logic f, logic s, logic [15:0] p, logic [23:0] q, logic [31:0] id);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= '{func: f, side: s, price: p, quantity: q, order_id: id};
		do @(posedge clk); while (busy);
		sb.note_request('{func: f, side: s, price: p, quantity: q, order_id: id});
		if (f == FuncAdd) ids = {ids, id};
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_id();
		if (ids.size() != 0 && $urandom_range(0, 3) != 0)
			return ids[$urandom_range(0, ids.size() - 1)];
		return $urandom_range(0, 40);
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, ties, zero quantity, cancel both sides, full book
		send(FuncAdd, SideBuy, 16'h0000, 24'hFFFFFF, 32'hFFFFFFFF);
		send(FuncAdd, SideSell, 16'hFFFF, 24'd10, 32'd1);
		send(FuncAdd, SideSell, 16'd100, 24'd5, 32'd2);
		send(FuncAdd, SideSell, 16'd100, 24'd7, 32'd3);
		send(FuncAdd, SideBuy, 16'd100, 24'd0, 32'd9);
		send(FuncAdd, SideBuy, 16'hFFFF, 24'd20, 32'd4);
		send(FuncAdd, SideSell, 16'd0, 24'd3, 32'd5);
		send(FuncCancel, SideSell, 16'hFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
		send(FuncCancel, SideBuy, 16'd0, 24'd0, 32'd77);
		send(FuncAdd, SideSell, 16'd50, 24'd4, 32'd6);
		send(FuncCancel, SideBuy, 16'd0, 24'd0, 32'd6);
		for (int i = 0; i < Depth + 2; i++)
			send(FuncAdd, SideBuy, 16'd10 + i[15:0], 24'd1, 32'd100 + i);
		send(FuncAdd, SideSell, 16'd0, 24'hFFFFFF, 32'hAAAA5555);
		drain();
		// Random: mostly adds around a narrow price band with reused ids
		for (int n = 0; n < 104; n++) begin
			if (n == 52) drain();
			if ($urandom_range(0, 5) == 0)
				send(FuncCancel, 1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom),
					pick_id());
			else if ($urandom_range(0, 9) == 0)
				send(FuncAdd, 1'($urandom_range(0, 1)), 16'($urandom), 24'($urandom),
					$urandom);
			else
				send(FuncAdd, 1'($urandom_range(0, 1)), 16'(1000 + $urandom_range(0, 8)),
					24'($urandom_range(0, 30)), pick_id());
		end
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
